FILE: design/assert_macros.svh
// Assertion macros for the prime element filter.
// Each macro expects signals named clock and reset in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PEF_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define PEF_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

FILE: design/pef_pkg.sv
// Shared types and constants for the prime element filter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package pef_pkg;

   // Smallest prime, also the first trial divisor
   localparam int unsigned MIN_PRIME     = 2;
   localparam int unsigned FIRST_DIVISOR = 2;

   // Top level to sequencer
   typedef struct packed {
      logic start;
      logic ack;
   } seq_ctrl_type;

   // Sequencer to top level
   typedef struct packed {
      logic idle;
      logic done;
      logic prime;
   } seq_status_type;

   // Remainder unit to sequencer
   typedef struct packed {
      logic done;
      logic zero;
   } rem_status_type;

endpackage

`default_nettype wire

FILE: design/pef_rem_unit.sv
// Shift-and-subtract remainder unit: one dividend bit per cycle.
// Depends on pef_pkg for its status type.
`timescale 1ns / 1ps
`default_nettype none

module pef_rem_unit #(
   parameter int VALUE_WIDTH = 32
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic [VALUE_WIDTH-1:0]         dividend,
   input  wire logic [(VALUE_WIDTH+1)/2-1:0]   divisor,
   output pef_pkg::rem_status_type             status
);
   import pef_pkg::*;

   localparam int DW = (VALUE_WIDTH + 1) / 2;
   localparam int CW = $clog2(VALUE_WIDTH);

   typedef enum logic {R_IDLE, R_RUN} state_type;

   state_type              state_ff,    state_in;
   logic [VALUE_WIDTH-1:0] dividend_ff, dividend_in;
   logic [DW-1:0]          divisor_ff,  divisor_in;
   logic [DW-1:0]          rem_ff,      rem_in;
   logic [CW-1:0]          count_ff,    count_in;
   logic                   done_ff,     done_in;

   logic [DW:0] trial;
   logic [DW:0] diff;
   logic [DW-1:0] rem_step;

   // Partial remainder stays below the divisor, so trial stays below twice it
   assign trial    = {rem_ff, dividend_ff[VALUE_WIDTH-1]};
   assign diff     = trial - {1'b0, divisor_ff};
   assign rem_step = (trial >= {1'b0, divisor_ff}) ? diff[DW-1:0] : trial[DW-1:0];

   always_comb begin
      state_in    = state_ff;
      dividend_in = dividend_ff;
      divisor_in  = divisor_ff;
      rem_in      = rem_ff;
      count_in    = count_ff;
      done_in     = 1'b0;
      case (state_ff)
         R_IDLE: begin
            if (start) begin
               dividend_in = dividend;
               divisor_in  = divisor;
               rem_in      = '0;
               count_in    = CW'(VALUE_WIDTH - 1);
               state_in    = R_RUN;
            end
         end
         R_RUN: begin
            rem_in      = rem_step;
            dividend_in = dividend_ff << 1;
            count_in    = count_ff - 1'b1;
            if (count_ff == '0) begin
               done_in  = 1'b1;
               state_in = R_IDLE;
            end
         end
         default: begin
            state_in = R_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= R_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      dividend_ff <= dividend_in;
      divisor_ff  <= divisor_in;
      rem_ff      <= rem_in;
      count_ff    <= count_in;
   end

   assign status.done = done_ff;
   assign status.zero = (rem_ff == '0);

endmodule

`default_nettype wire

FILE: design/pef_seq.sv
// Trial-division sequencer: steps the divisor and its running square and
// drives the shared remainder unit. Depends on pef_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pef_seq #(
   parameter int VALUE_WIDTH = 32
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire pef_pkg::seq_ctrl_type          ctrl,
   input  wire logic [VALUE_WIDTH-1:0]         load_value,
   input  wire pef_pkg::rem_status_type        rem_status,
   output pef_pkg::seq_status_type             status,
   output logic [VALUE_WIDTH-1:0]              held_value,
   output logic [(VALUE_WIDTH+1)/2-1:0]        divisor,
   output logic                                rem_start
);
   import pef_pkg::*;

   localparam int DW = (VALUE_WIDTH + 1) / 2;
   localparam int SW = VALUE_WIDTH + 1;

   typedef enum logic [1:0] {S_IDLE, S_CHECK, S_DIVIDE, S_DONE} state_type;

   state_type              state_ff,   state_in;
   logic [VALUE_WIDTH-1:0] value_ff,   value_in;
   logic [DW-1:0]          divisor_ff, divisor_in;
   logic [SW-1:0]          square_ff,  square_in;
   logic                   prime_ff,   prime_in;

   always_comb begin
      state_in   = state_ff;
      value_in   = value_ff;
      divisor_in = divisor_ff;
      square_in  = square_ff;
      prime_in   = prime_ff;
      rem_start  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (ctrl.start) begin
               value_in   = load_value;
               divisor_in = DW'(FIRST_DIVISOR);
               square_in  = SW'(FIRST_DIVISOR * FIRST_DIVISOR);
               prime_in   = 1'b0;
               // Negative values and values below two skip the division loop
               if (load_value[VALUE_WIDTH-1] || (load_value < VALUE_WIDTH'(MIN_PRIME))) begin
                  state_in = S_DONE;
               end else begin
                  state_in = S_CHECK;
               end
            end
         end
         S_CHECK: begin
            if (square_ff > {1'b0, value_ff}) begin
               prime_in = 1'b1;
               state_in = S_DONE;
            end else begin
               rem_start = 1'b1;
               state_in  = S_DIVIDE;
            end
         end
         S_DIVIDE: begin
            if (rem_status.done) begin
               if (rem_status.zero) begin
                  prime_in = 1'b0;
                  state_in = S_DONE;
               end else begin
                  // (d+1)^2 = d^2 + 2d + 1
                  divisor_in = divisor_ff + 1'b1;
                  square_in  = square_ff + SW'({divisor_ff, 1'b1});
                  state_in   = S_CHECK;
               end
            end
         end
         S_DONE: begin
            if (ctrl.ack) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff   <= value_in;
      divisor_ff <= divisor_in;
      square_ff  <= square_in;
      prime_ff   <= prime_in;
   end

   assign status.idle  = (state_ff == S_IDLE);
   assign status.done  = (state_ff == S_DONE);
   assign status.prime = prime_ff;
   assign held_value   = value_ff;
   assign divisor      = divisor_ff;

endmodule

`default_nettype wire

FILE: design/prime_element_filter.sv
// Prime element filter top level: input capture, result register and handshakes.
// Depends on pef_pkg, pef_seq, pef_rem_unit and assert_macros.svh.
//
//   channel  direction  handshake          payload
//   req      in         req_valid/stall    element_value, row_end, matrix_end
//   rsp      out        rsp_valid/stall    kept_value, is_prime, row_end_out, matrix_end_out
//
// One element at a time. Negative values and values below two skip the division
// loop and go straight to the sequencer's done state. Otherwise each trial
// divisor makes one pass through the shared bit-serial remainder unit, for up
// to about sqrt(2^(VALUE_WIDTH-1)) divisors.
// Synchronous reset leaves the block idle with no result pending.
// A new element is taken while a finished result waits in the output register;
// a further result holds in the sequencer until that register frees up.
`timescale 1ns / 1ps
`default_nettype none

module prime_element_filter #(
   parameter int VALUE_WIDTH = 32
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic signed [31:0] req_element_value,
   input  wire logic               req_row_end,
   input  wire logic               req_matrix_end,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [31:0]      rsp_kept_value,
   output logic                    rsp_is_prime,
   output logic                    rsp_row_end_out,
   output logic                    rsp_matrix_end_out
);
   import pef_pkg::*;

   localparam int DW = (VALUE_WIDTH + 1) / 2;

   seq_ctrl_type           seq_ctrl;
   seq_status_type         seq_status;
   rem_status_type         rem_status;
   logic [VALUE_WIDTH-1:0] held_value;
   logic [DW-1:0]          divisor;
   logic                   rem_start;
   logic                   req_xfer;

   logic                   row_end_ff,    row_end_in;
   logic                   matrix_end_ff, matrix_end_in;
   logic                   rsp_valid_ff,  rsp_valid_in;
   logic signed [31:0]     kept_ff,       kept_in;
   logic                   prime_ff,      prime_in;
   logic                   rsp_row_ff,    rsp_row_in;
   logic                   rsp_mat_ff,    rsp_mat_in;

   assign req_stall      = !seq_status.idle;
   assign req_xfer       = req_valid && !req_stall;
   assign seq_ctrl.start = req_xfer;
   // Release the sequencer once the output register can take its result
   assign seq_ctrl.ack   = seq_status.done && (!rsp_valid_ff || !rsp_stall);

   pef_seq #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (seq_ctrl),
      .load_value (req_element_value[VALUE_WIDTH-1:0]),
      .rem_status (rem_status),
      .status     (seq_status),
      .held_value (held_value),
      .divisor    (divisor),
      .rem_start  (rem_start)
   );

   pef_rem_unit #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (rem_start),
      .dividend (held_value),
      .divisor  (divisor),
      .status   (rem_status)
   );

   always_comb begin
      row_end_in    = row_end_ff;
      matrix_end_in = matrix_end_ff;
      if (req_xfer) begin
         row_end_in    = req_row_end;
         matrix_end_in = req_matrix_end;
      end

      rsp_valid_in = rsp_valid_ff;
      kept_in      = kept_ff;
      prime_in     = prime_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_mat_in   = rsp_mat_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (seq_ctrl.ack) begin
         rsp_valid_in = 1'b1;
         // Tested values are non-negative, so zero extension keeps the value
         kept_in      = seq_status.prime ? 32'(held_value) : '0;
         prime_in     = seq_status.prime;
         rsp_row_in   = row_end_ff;
         rsp_mat_in   = matrix_end_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      row_end_ff    <= row_end_in;
      matrix_end_ff <= matrix_end_in;
      kept_ff       <= kept_in;
      prime_ff      <= prime_in;
      rsp_row_ff    <= rsp_row_in;
      rsp_mat_ff    <= rsp_mat_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kept_value     = kept_ff;
   assign rsp_is_prime       = prime_ff;
   assign rsp_row_end_out    = rsp_row_ff;
   assign rsp_matrix_end_out = rsp_mat_ff;

`include "assert_macros.svh"

   `PEF_ASSERT_NEXT(a_stall_after_transfer, req_valid && !req_stall, req_stall)
   `PEF_ASSERT_SAME(a_prime_flag_matches_value, rsp_valid, rsp_is_prime == (rsp_kept_value != 0))
   `PEF_ASSERT_SAME(a_result_held_blocks_req, seq_status.done && rsp_valid && rsp_stall, req_stall)

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking testbench for prime_element_filter: directed extremes, random matrices,
// a receiver hold-off and a back-to-back run. Depends on pef_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_top;
   import pef_pkg::*;

   localparam int CLOCK_HALF        = 5;
   localparam int RESET_CYCLES      = 8;
   localparam int CYCLE_LIMIT       = 12_000_000;
   localparam int SETTLE_CYCLES     = 200;
   localparam int HOLDOFF_CYCLES    = 2000;
   localparam int RANDOM_ELEMENTS   = 50;
   localparam int MAX_REPORTED      = 10;

   typedef struct {
      logic signed [31:0] kept_value;
      logic               is_prime;
      logic               row_end_out;
      logic               matrix_end_out;
   } filter_result_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic signed [31:0] req_element_value;
   logic               req_row_end;
   logic               req_matrix_end;
   logic               rsp_valid;
   logic               rsp_stall;
   logic signed [31:0] rsp_kept_value;
   logic               rsp_is_prime;
   logic               rsp_row_end_out;
   logic               rsp_matrix_end_out;

   filter_result_type expected_filtered[$];
   bit                idling_on;
   int                holdoff_left;
   int                failure_count;
   int                elements_sent;
   int                results_checked;
   int                primes_checked;
   int                input_stall_cycles;
   int                cycle_count;

   prime_element_filter u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_element_value  (req_element_value),
      .req_row_end        (req_row_end),
      .req_matrix_end     (req_matrix_end),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_kept_value     (rsp_kept_value),
      .rsp_is_prime       (rsp_is_prime),
      .rsp_row_end_out    (rsp_row_end_out),
      .rsp_matrix_end_out (rsp_matrix_end_out)
   );

   always begin
      clock = 1'b0;
      #CLOCK_HALF;
      clock = 1'b1;
      #CLOCK_HALF;
   end

   // Trial division: any zero remainder with divisor squared within the value rules it out.
   function automatic filter_result_type predict_filtered(logic signed [31:0] element,
                                                          logic row_end, logic matrix_end);
      filter_result_type outcome;
      longint            value;
      longint            divisor;
      bit                prime;
      value = element;
      prime = value >= longint'(MIN_PRIME);
      for (divisor = longint'(FIRST_DIVISOR); prime && divisor * divisor <= value;
           divisor++) begin
         if (value % divisor == 0) prime = 1'b0;
      end
      outcome.kept_value     = prime ? element : '0;
      outcome.is_prime       = prime;
      outcome.row_end_out    = row_end;
      outcome.matrix_end_out = matrix_end;
      return outcome;
   endfunction

   function automatic void log_failure(string msg);
      failure_count++;
      if (failure_count <= MAX_REPORTED) $display("MISMATCH at %0t: %s", $realtime, msg);
   endfunction

   // Mostly small values; large ones carry a small factor or a sign bit so tests stay short.
   function automatic logic signed [31:0] random_element();
      logic [31:0] bits;
      bits = $urandom;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return $urandom_range(0, 300);
         4:          return $urandom_range(0, 65535);
         5:          return {1'b1, bits[30:0]};
         6:          return {1'b0, bits[30:1], 1'b0};
         7:          return 3 * $urandom_range(0, 715827882);
         8:          return $signed($urandom_range(0, 40)) - 20;
         default:    return $urandom_range(0, 262143);
      endcase
   endfunction

   // Drive one element and hold it until the block takes it.
   task automatic send_element(logic signed [31:0] element, logic row_end, logic matrix_end);
      int gap;
      gap = (idling_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_element_value <= element;
      req_row_end       <= row_end;
      req_matrix_end    <= matrix_end;
      do @(posedge clock); while (req_stall);
      expected_filtered.push_back(predict_filtered(element, row_end, matrix_end));
      elements_sent++;
   endtask

   // Drop valid and hold until every outstanding result has been checked.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_filtered.size() != 0) @(posedge clock);
   endtask

   task automatic send_random_matrix();
      int rows;
      int cols;
      rows = $urandom_range(1, 4);
      for (int r = 0; r < rows; r++) begin
         cols = $urandom_range(1, 6);
         for (int c = 0; c < cols; c++) begin
            send_element(random_element(), c == cols - 1, r == rows - 1 && c == cols - 1);
         end
      end
   endtask

   task automatic test_directed_extremes();
      send_element(0, 1'b0, 1'b0);
      send_element(1, 1'b0, 1'b0);
      send_element(-1, 1'b1, 1'b0);
      send_element(32'sh8000_0000, 1'b0, 1'b0);
      send_element(2, 1'b0, 1'b0);
      send_element(3, 1'b1, 1'b0);
      send_element(4, 1'b0, 1'b0);
      send_element(5, 1'b0, 1'b1);
      send_element(9, 1'b1, 1'b1);
      send_element(25, 1'b0, 1'b0);
      send_element(97, 1'b1, 1'b0);
      send_element(121, 1'b0, 1'b0);
      // square of a prime sits exactly on the divisor bound
      send_element(63001, 1'b0, 1'b0);
      send_element(65521, 1'b1, 1'b0);
      send_element(65536, 1'b0, 1'b0);
      send_element(-2, 1'b0, 1'b1);
      send_element(32'sh7FFF_FFFE, 1'b0, 1'b0);
      send_element(32'sh5555_5555, 1'b1, 1'b0);
      send_element(32'shAAAA_AAAA, 1'b0, 1'b0);
      // largest positive value is itself prime: the slowest single element
      send_element(32'sh7FFF_FFFF, 1'b1, 1'b1);
      wait_for_results();
   endtask

   task automatic test_random_matrices();
      int start_count;
      start_count = elements_sent;
      while (elements_sent - start_count < RANDOM_ELEMENTS) begin
         // occasional stray element with arbitrary marks
         if ($urandom_range(0, 7) == 0) begin
            send_element(random_element(), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)));
         end else begin
            send_random_matrix();
         end
      end
      wait_for_results();
   endtask

   task automatic test_output_holdoff();
      idling_on    = 1'b0;
      holdoff_left = HOLDOFF_CYCLES;
      for (int i = 0; i < 8; i++) begin
         send_element($urandom_range(0, 60), i % 4 == 3, i == 7);
      end
      wait_for_results();
   endtask

   task automatic test_back_to_back();
      idling_on = 1'b0;
      for (int i = 0; i < 24; i++) begin
         send_element($urandom_range(0, 500), i % 6 == 5, i == 23);
      end
      wait_for_results();
   endtask

   // Receiver side: random stall bursts plus the long hold-off when one is requested.
   initial begin : result_stall_driver
      int burst_left;
      burst_left = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (holdoff_left > 0) begin
            rsp_stall <= 1'b1;
            holdoff_left--;
         end else if (burst_left > 0) begin
            rsp_stall <= 1'b1;
            burst_left--;
         end else if (idling_on && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            burst_left = $urandom_range(1, 12) - 1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : result_checker
      filter_result_type want;
      if (!reset) begin
         if (req_valid && req_stall) input_stall_cycles++;
         if (rsp_valid && !rsp_stall) begin
            if (expected_filtered.size() == 0) begin
               log_failure($sformatf("unexpected result kept_value=%0d", rsp_kept_value));
            end else begin
               want = expected_filtered.pop_front();
               results_checked++;
               if (want.is_prime) primes_checked++;
               if (rsp_kept_value !== want.kept_value)
                  log_failure($sformatf("kept_value expected %0d got %0d",
                                        want.kept_value, rsp_kept_value));
               if (rsp_is_prime !== want.is_prime)
                  log_failure($sformatf("is_prime expected %0b got %0b (value %0d)",
                                        want.is_prime, rsp_is_prime, want.kept_value));
               if (rsp_row_end_out !== want.row_end_out)
                  log_failure($sformatf("row_end_out expected %0b got %0b",
                                        want.row_end_out, rsp_row_end_out));
               if (rsp_matrix_end_out !== want.matrix_end_out)
                  log_failure($sformatf("matrix_end_out expected %0b got %0b",
                                        want.matrix_end_out, rsp_matrix_end_out));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results outstanding",
                  cycle_count, expected_filtered.size());
         $display("[prime_element_filter] ERROR");
         $finish;
      end
   end

   initial begin
      idling_on         = 1'b1;
      holdoff_left      = 0;
      reset             <= 1'b1;
      req_valid         <= 1'b0;
      req_element_value <= '0;
      req_row_end       <= 1'b0;
      req_matrix_end    <= 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_extremes();
      test_random_matrices();
      test_output_holdoff();
      test_back_to_back();

      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Covered %0d elements (%0d prime) over directed, matrix, hold-off and",
               results_checked, primes_checked);
      $display("back-to-back phases; input held off for %0d cycles", input_stall_cycles);
      if (failure_count == 0 && expected_filtered.size() == 0) begin
         $display("[prime_element_filter] OK");
      end else begin
         $display("%0d failures", failure_count);
         $display("[prime_element_filter] ERROR");
      end
      $finish;
   end

endmodule
